// ===== rtl/tdlst_pkg.sv =====
// ----------------------------------------------------------------------------
// Time-of-day load switch timer package
// Shared widths, codes and types for the timer core and its channel slices.
// ----------------------------------------------------------------------------
package tdlst_pkg;

	localparam int DEF_CHANNELS = 4;
	localparam int NUM_REGS     = 4;
	localparam int OUT_BITS     = 4;
	localparam int CFG_INDEX_W  = 3;
	localparam int SETTING_W    = 24;
	localparam int HOUR_W       = 5;
	localparam int MINUTE_W     = 6;
	localparam int PERIOD_W     = 12;
	localparam int CNT_W        = 11;

	localparam logic [CNT_W-1:0]    CNT_MAX     = 11'd2047;
	localparam logic [MINUTE_W-1:0] LAST_MINUTE = 6'd59;
	localparam logic [HOUR_W-1:0]   LAST_HOUR   = 5'd23;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SET  = 1'b1;

	typedef struct packed {
		logic                enable;
		logic [PERIOD_W-1:0] period;
		logic [MINUTE_W-1:0] start_minute;
		logic [HOUR_W-1:0]   start_hour;
	} setting_t;

	typedef struct packed {
		logic load;
		logic running;
	} chan_status_t;

endpackage

// ===== rtl/time_of_day_load_switch_timer_core.sv =====
// ----------------------------------------------------------------------------
// Time-of-day load switch timer core
// Stages: input and result, each one register; a beat moves from one to the other.
// Throughput: one item per cycle while results are not stalled.
// While a result waits, the input register still takes one beat, then the input stalls.
// Reset clears the clock, all run counters, all loads and the settings.
// ----------------------------------------------------------------------------
module time_of_day_load_switch_timer_core #(
	parameter int CHANNELS = tdlst_pkg::DEF_CHANNELS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tdlst_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tdlst_pkg::SETTING_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic [tdlst_pkg::HOUR_W-1:0]      set_hour,
	input  logic [tdlst_pkg::MINUTE_W-1:0]    set_minute,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tdlst_pkg::OUT_BITS-1:0]    load_on,
	output logic [tdlst_pkg::OUT_BITS-1:0]    channel_running,
	output logic [tdlst_pkg::HOUR_W-1:0]      clock_hour,
	output logic [tdlst_pkg::MINUTE_W-1:0]    clock_minute
);
	import tdlst_pkg::*;

	setting_t setting_q [NUM_REGS];

	logic                valid_s1;
	logic                op_s1;
	logic [HOUR_W-1:0]   hour_s1;
	logic [MINUTE_W-1:0] minute_s1;

	logic [HOUR_W-1:0]   hour_q;
	logic [MINUTE_W-1:0] minute_q;
	logic [HOUR_W-1:0]   hour_d;
	logic [MINUTE_W-1:0] minute_d;

	logic                out_valid_q;
	logic [OUT_BITS-1:0] load_q;
	logic [OUT_BITS-1:0] running_q;
	logic [HOUR_W-1:0]   out_hour_q;
	logic [MINUTE_W-1:0] out_minute_q;

	logic                advance;
	logic                tick;
	chan_status_t        status_nxt [CHANNELS];
	logic [OUT_BITS-1:0] load_nxt;
	logic [OUT_BITS-1:0] running_nxt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				setting_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready && cfg_index < CFG_INDEX_W'(NUM_REGS)) begin
			setting_q[cfg_index[$clog2(NUM_REGS)-1:0]] <= setting_t'(cfg_data);
		end
	end

	// The held item moves on when the result register is empty or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign tick     = advance && (op_s1 == OP_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1     <= operation;
			hour_s1   <= set_hour;
			minute_s1 <= set_minute;
		end
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		setting_t chan_setting;
		if (c < NUM_REGS) begin : g_reg
			assign chan_setting = setting_q[c];
		end else begin : g_none
			assign chan_setting = '0;
		end
		tdlst_channel u_channel (
			.clk        (clk),
			.arst_n     (arst_n),
			.tick       (tick),
			.hour       (hour_q),
			.minute     (minute_q),
			.setting    (chan_setting),
			.status_nxt (status_nxt[c])
		);
	end

	for (genvar b = 0; b < OUT_BITS; b++) begin : g_out
		if (b < CHANNELS) begin : g_used
			assign load_nxt[b]    = status_nxt[b].load;
			assign running_nxt[b] = status_nxt[b].running;
		end else begin : g_unused
			assign load_nxt[b]    = 1'b0;
			assign running_nxt[b] = 1'b0;
		end
	end

	always_comb begin
		hour_d   = hour_q;
		minute_d = minute_q;
		if (advance) begin
			unique case (op_s1)
				OP_SET: begin
					hour_d   = hour_s1;
					minute_d = minute_s1;
				end
				OP_TICK: begin
					if (minute_q >= LAST_MINUTE) begin
						minute_d = '0;
						hour_d   = (hour_q >= LAST_HOUR) ? '0 : hour_q + HOUR_W'(1);
					end else begin
						minute_d = minute_q + MINUTE_W'(1);
					end
				end
				default: begin
					hour_d   = hour_q;
					minute_d = minute_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q   <= '0;
			minute_q <= '0;
		end else begin
			hour_q   <= hour_d;
			minute_q <= minute_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			load_q       <= load_nxt;
			running_q    <= running_nxt;
			out_hour_q   <= hour_d;
			out_minute_q <= minute_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign load_on         = load_q;
	assign channel_running = running_q;
	assign clock_hour      = out_hour_q;
	assign clock_minute    = out_minute_q;

endmodule

// ===== rtl/tdlst_channel.sv =====
// ----------------------------------------------------------------------------
// Load switch channel
// Holds one channel's run counter and load state and steps them on a tick.
// ----------------------------------------------------------------------------
module tdlst_channel (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           tick,
	input  logic [tdlst_pkg::HOUR_W-1:0]   hour,
	input  logic [tdlst_pkg::MINUTE_W-1:0] minute,
	input  tdlst_pkg::setting_t            setting,
	output tdlst_pkg::chan_status_t        status_nxt
);
	import tdlst_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic             load_q;
	logic [CNT_W-1:0] cnt_d;
	logic             load_d;
	logic [CNT_W-1:0] cnt_start;

	always_comb begin
		cnt_d  = cnt_q;
		load_d = load_q;
		if (tick) begin
			cnt_start = cnt_q;
			if (hour == setting.start_hour && minute == setting.start_minute
				&& cnt_q == '0) begin
				cnt_start = CNT_W'(1);
			end
			cnt_d = cnt_start;
			if (cnt_start != '0 && setting.enable) begin
				load_d = 1'b1;
				if ({1'b0, cnt_start} > setting.period) begin
					cnt_d  = '0;
					load_d = 1'b0;
				end else if (cnt_start != CNT_MAX) begin
					cnt_d = cnt_start + CNT_W'(1);
				end
			end
			if (!setting.enable) begin
				load_d = 1'b0;
			end
		end else begin
			cnt_start = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			load_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			load_q <= load_d;
		end
	end

	assign status_nxt.load    = load_d;
	assign status_nxt.running = (cnt_d != '0);

endmodule

// ===== bench/timer_status_check.sv =====
// ----------------------------------------------------------------------------
// Timer status checker
// Follows the configuration, input and result channels of the load switch
// timer core. It keeps its own copy of the clock, run counters, loads and
// alarm settings, works out the status beat each accepted item should
// produce, and compares every result beat field by field with the oldest one.
// ----------------------------------------------------------------------------
module timer_status_check (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [tdlst_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tdlst_pkg::SETTING_W-1:0]   cfg_data,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              operation,
	input  logic [tdlst_pkg::HOUR_W-1:0]      set_hour,
	input  logic [tdlst_pkg::MINUTE_W-1:0]    set_minute,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [tdlst_pkg::OUT_BITS-1:0]    load_on,
	input  logic [tdlst_pkg::OUT_BITS-1:0]    channel_running,
	input  logic [tdlst_pkg::HOUR_W-1:0]      clock_hour,
	input  logic [tdlst_pkg::MINUTE_W-1:0]    clock_minute,
	output int                                errors,
	output int                                pending,
	output int                                results_seen,
	output int                                runs_started,
	output int                                runs_ended,
	output int                                saturations
);

	import tdlst_pkg::*;

	typedef struct packed {
		logic [OUT_BITS-1:0] load_on;
		logic [OUT_BITS-1:0] running;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
	} timer_status_t;

	setting_t            alarm_cfg [NUM_REGS];
	logic [HOUR_W-1:0]   hour_q;
	logic [MINUTE_W-1:0] minute_q;
	logic [CNT_W-1:0]    run_cnt [DEF_CHANNELS];
	logic                load_q [DEF_CHANNELS];
	timer_status_t       due_status_q [$];

	function automatic void run_channel(input int ch);
		setting_t s;
		s = alarm_cfg[ch];
		if (hour_q == s.start_hour && minute_q == s.start_minute && run_cnt[ch] == '0) begin
			run_cnt[ch] = CNT_W'(1);
			runs_started++;
		end
		if (run_cnt[ch] != '0 && s.enable) begin
			load_q[ch] = 1'b1;
			// The period is a bit wider than the counter, so compare at its width.
			if ({1'b0, run_cnt[ch]} > s.period) begin
				run_cnt[ch] = '0;
				load_q[ch] = 1'b0;
				runs_ended++;
			end else if (run_cnt[ch] < CNT_MAX) begin
				run_cnt[ch] = run_cnt[ch] + 1'b1;
				if (run_cnt[ch] == CNT_MAX)
					saturations++;
			end
		end
		if (!s.enable)
			load_q[ch] = 1'b0;
	endfunction

	function automatic void apply_item(input logic op, input logic [HOUR_W-1:0] h,
			input logic [MINUTE_W-1:0] m);
		timer_status_t st;
		if (op == OP_SET) begin
			hour_q = h;
			minute_q = m;
		end else begin
			for (int ch = 0; ch < DEF_CHANNELS; ch++)
				run_channel(ch);
			// Out-of-range times wrap on the next tick rather than being refused.
			if (minute_q >= LAST_MINUTE) begin
				minute_q = '0;
				hour_q = (hour_q >= LAST_HOUR) ? '0 : hour_q + 1'b1;
			end else begin
				minute_q = minute_q + 1'b1;
			end
		end
		st = '0;
		for (int ch = 0; ch < DEF_CHANNELS && ch < OUT_BITS; ch++) begin
			st.load_on[ch] = load_q[ch];
			st.running[ch] = (run_cnt[ch] != '0);
		end
		st.hour = hour_q;
		st.minute = minute_q;
		due_status_q.push_back(st);
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		timer_status_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				alarm_cfg[i] = '0;
			for (int ch = 0; ch < DEF_CHANNELS; ch++) begin
				run_cnt[ch] = '0;
				load_q[ch] = 1'b0;
			end
			hour_q = '0;
			minute_q = '0;
			due_status_q.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (due_status_q.size() == 0) begin
					$error("status beat arrived with no item outstanding");
					errors++;
				end else begin
					want = due_status_q.pop_front();
					check_field("load_on", 8'(want.load_on), 8'(load_on));
					check_field("channel_running", 8'(want.running), 8'(channel_running));
					check_field("clock_hour", 8'(want.hour), 8'(clock_hour));
					check_field("clock_minute", 8'(want.minute), 8'(clock_minute));
				end
			end
			// Writes to an index past the register list have no effect.
			if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
				alarm_cfg[cfg_index[$clog2(NUM_REGS)-1:0]] = setting_t'(cfg_data);
			if (in_valid && !in_stall)
				apply_item(operation, set_hour, set_minute);
			pending <= due_status_q.size();
		end
	end

endmodule

// ===== bench/tb_time_of_day_load_switch_timer_core.sv =====
// ----------------------------------------------------------------------------
// Testbench for the time-of-day load switch timer core
// Programs the four alarm channels, feeds minute ticks and set-time items
// with random gaps and result stalls, and leaves the checking to the status
// checker. A directed opening covers wraps, out-of-range times and extreme
// settings; random phases and a soak with long run periods follow.
// ----------------------------------------------------------------------------
module tb_time_of_day_load_switch_timer_core;

	import tdlst_pkg::*;

	localparam int RESET_CYCLES  = 6;
	localparam int DRAIN_CYCLES  = 4;
	localparam int HOLD_CYCLES   = 48;
	localparam int QUIET_LIMIT   = 600;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 120;
	localparam int SOAK_TICKS    = 460;

	logic                   clk             = 1'b0;
	logic                   arst_n          = 1'b0;
	logic                   cfg_valid       = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index       = '0;
	logic [SETTING_W-1:0]   cfg_data        = '0;
	logic                   in_valid        = 1'b0;
	logic                   in_stall;
	logic                   operation       = OP_TICK;
	logic [HOUR_W-1:0]      set_hour        = '0;
	logic [MINUTE_W-1:0]    set_minute      = '0;
	logic                   out_valid;
	logic                   out_stall       = 1'b0;
	logic [OUT_BITS-1:0]    load_on;
	logic [OUT_BITS-1:0]    channel_running;
	logic [HOUR_W-1:0]      clock_hour;
	logic [MINUTE_W-1:0]    clock_minute;

	int errors;
	int pending;
	int results_seen;
	int runs_started;
	int runs_ended;
	int saturations;
	int items_sent  = 0;
	int sets_sent   = 0;
	int phases_run  = 0;
	int idle_pct    = 0;
	int quiet_count = 0;
	bit rx_hold     = 1'b0;

	setting_t plan [NUM_REGS];

	time_of_day_load_switch_timer_core DUT (.*);

	timer_status_check u_status_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic setting_t alarm_word(input logic en, input int period, input int h,
			input int m);
		setting_t s;
		s.enable = en;
		s.period = PERIOD_W'(period);
		s.start_hour = HOUR_W'(h);
		s.start_minute = MINUTE_W'(m);
		return s;
	endfunction

	function automatic setting_t random_alarm();
		setting_t s;
		int pick;
		pick = $urandom_range(0, 99);
		s.enable = ($urandom_range(0, 99) < 80);
		s.start_hour = (pick < 10) ? HOUR_W'($urandom_range(24, 31))
			: HOUR_W'($urandom_range(0, 23));
		s.start_minute = (pick >= 90) ? MINUTE_W'($urandom_range(60, 63))
			: MINUTE_W'($urandom_range(0, 59));
		case ($urandom_range(0, 9))
			0: s.period = PERIOD_W'($urandom_range(0, 4095));
			1: s.period = '0;
			default: s.period = PERIOD_W'($urandom_range(1, 40));
		endcase
		return s;
	endfunction

	// Writes the four alarm registers from the plan, then one stray index.
	task automatic program_alarms();
		for (int i = 0; i <= NUM_REGS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= (i < NUM_REGS) ? CFG_INDEX_W'(i)
				: CFG_INDEX_W'(NUM_REGS + $urandom_range(0, 3));
			cfg_data <= (i < NUM_REGS) ? SETTING_W'(plan[i]) : SETTING_W'($urandom);
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(input logic op, input logic [HOUR_W-1:0] h,
			input logic [MINUTE_W-1:0] m);
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		set_hour <= h;
		set_minute <= m;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (op == OP_SET)
			sets_sent++;
	endtask

	task automatic send_tick();
		send_item(OP_TICK, HOUR_W'($urandom_range(0, 31)), MINUTE_W'($urandom_range(0, 63)));
	endtask

	// Stops offering and waits until every status beat has come back.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : receiver
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				out_stall <= 1'b1;
				n = 0;
				while (n < HOLD_CYCLES) begin
					@(posedge clk);
					n++;
				end
				out_stall <= 1'b0;
				rx_hold = 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_count <= 0;
		end else if (arst_n) begin
			quiet_count <= quiet_count + 1;
			if (quiet_count >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int pick;
		int k;
		int off;
		logic [HOUR_W-1:0]   h;
		logic [MINUTE_W-1:0] m;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: short periods, an all-ones channel, a frozen channel.
		idle_pct = 10;
		plan[0] = alarm_word(1'b1, 0, 0, 5);
		plan[1] = alarm_word(1'b1, 1, 0, 5);
		plan[2] = setting_t'({SETTING_W{1'b1}});
		plan[3] = alarm_word(1'b0, 3, 0, 5);
		program_alarms();
		send_tick();
		send_item(OP_SET, 5'd0, 6'd4);
		repeat (3) send_tick();
		// All-ones start time is only reachable by loading an out-of-range clock.
		send_item(OP_SET, 5'd31, 6'd63);
		send_tick();
		send_item(OP_SET, 5'd23, 6'd58);
		repeat (2) send_tick();
		send_item(OP_SET, 5'd22, 6'd59);
		send_tick();
		send_item(OP_SET, 5'd0, 6'd0);
		send_item(OP_SET, 5'd31, 6'd0);
		send_item(OP_SET, 5'd0, 6'd63);
		settle();
		plan[0] = '0;
		plan[3].enable = 1'b1;
		program_alarms();
		repeat (3) send_tick();
		settle();
		for (int c = 0; c < NUM_REGS; c++)
			plan[c] = '0;
		program_alarms();
		repeat (2) send_tick();
		settle();
		phases_run = 3;

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 6 : 20;
			for (int c = 0; c < NUM_REGS; c++)
				plan[c] = random_alarm();
			program_alarms();
			phases_run++;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Hold results back while beats keep coming so the core backs up.
				if (p == 1 && n == 40) begin
					rx_hold = 1'b1;
					idle_pct = 0;
				end
				if (p == 1 && n == 80)
					idle_pct = 6;
				if (p == 3 && n == PHASE_ITEMS / 2)
					settle();
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					send_tick();
				end else if (pick < 85) begin
					// Land just ahead of a channel's start time so that it fires.
					k = $urandom_range(0, NUM_REGS - 1);
					h = plan[k].start_hour;
					m = plan[k].start_minute;
					off = $urandom_range(0, 3);
					if (m >= off)
						m = m - MINUTE_W'(off);
					send_item(OP_SET, h, m);
				end else if (pick < 92) begin
					send_item(OP_SET, HOUR_W'($urandom_range(22, 31)),
						MINUTE_W'($urandom_range(55, 63)));
				end else begin
					send_item(OP_SET, HOUR_W'($urandom_range(0, 31)),
						MINUTE_W'($urandom_range(0, 63)));
				end
			end
			settle();
		end

		// Soak with no idling: clear all counters, then keep long runs going,
		// one of which ends partway through.
		idle_pct = 0;
		for (int c = 0; c < NUM_REGS; c++)
			plan[c] = alarm_word(1'b1, 0, 31, 63);
		program_alarms();
		send_item(OP_SET, 5'd0, 6'd0);
		send_tick();
		settle();
		plan[0] = alarm_word(1'b1, 4095, 5, 0);
		plan[1] = alarm_word(1'b1, 2047, 5, 0);
		plan[2] = alarm_word(1'b1, 400, 5, 1);
		plan[3] = alarm_word(1'b0, 3, 5, 0);
		program_alarms();
		phases_run += 2;
		send_item(OP_SET, 5'd5, 6'd0);
		repeat (SOAK_TICKS) send_tick();
		settle();

		$display("Timer run: %0d items (%0d set-time), %0d status beats checked, %0d alarm setups.",
			items_sent, sets_sent, results_seen, phases_run);
		$display("Channel runs: %0d started, %0d ended, %0d counters reached their limit.",
			runs_started, runs_ended, saturations);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
